>>> sv/calendar_clock_counter_unit_macros.svh
// ---------------------------------------------------------------------------
// calendar clock counter assertion macros
// concurrent assertion helpers; they compile to nothing under synthesis
// ---------------------------------------------------------------------------
`ifndef CALENDAR_CLOCK_COUNTER_UNIT_MACROS_SVH
`define CALENDAR_CLOCK_COUNTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define CCC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("calendar clock counter assertion failed");
// checked on every edge, reset included
`define CCC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("calendar clock counter assertion failed");
`else
`define CCC_ASSERT(lbl, clk, rstn, prop)
`define CCC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> sv/ccc_pkg.sv
// ---------------------------------------------------------------------------
// calendar clock counter package
// field widths, counter limits, reset values and the month length lookup
// ---------------------------------------------------------------------------
package ccc_pkg;

  // field widths
  localparam int unsigned HourW  = 5;
  localparam int unsigned SetW   = 6;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned YearW  = 16;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;

  // counter limits
  localparam logic [HourW-1:0]  HourMax   = HourW'(23);
  localparam logic [MinW-1:0]   MinMax    = MinW'(59);
  localparam logic [SecW-1:0]   SecMax    = SecW'(59);
  localparam logic [MonthW-1:0] MonthMin  = MonthW'(1);
  localparam logic [MonthW-1:0] MonthMax  = MonthW'(12);
  localparam logic [DayW-1:0]   DayMin    = DayW'(1);

  // month codes with a length other than 31
  localparam logic [MonthW-1:0] MonthFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonthApr = MonthW'(4);
  localparam logic [MonthW-1:0] MonthJun = MonthW'(6);
  localparam logic [MonthW-1:0] MonthSep = MonthW'(9);
  localparam logic [MonthW-1:0] MonthNov = MonthW'(11);

  // values after reset
  localparam logic [HourW-1:0]  HourRst  = HourW'(23);
  localparam logic [MinW-1:0]   MinRst   = MinW'(59);
  localparam logic [SecW-1:0]   SecRst   = SecW'(56);
  localparam logic [YearW-1:0]  YearRst  = YearW'(2004);
  localparam logic [MonthW-1:0] MonthRst = MonthW'(12);
  localparam logic [DayW-1:0]   DayRst   = DayW'(31);

  // days in a month; leap year when the low two year bits are zero
  function automatic logic [DayW-1:0] month_len(input logic [1:0]        year_lo,
                                                input logic [MonthW-1:0] month);
    logic [DayW-1:0] len;
    case (month)
      MonthFeb: len = (year_lo == 2'b00) ? DayW'(29) : DayW'(28);
      MonthApr, MonthJun, MonthSep, MonthNov: len = DayW'(30);
      default: len = DayW'(31);
    endcase
    return len;
  endfunction

endpackage

>>> sv/calendar_clock_counter_unit.sv
// ---------------------------------------------------------------------------
// calendar clock counter unit
// real-time clock and calendar advanced by one-second ticks or loaded by set
// ---------------------------------------------------------------------------
// Each input beat is a one-second tick (mode_i = 0) or a load of time and
// date (mode_i = 1). The block takes one beat per clock cycle while the
// result side is not stalled; a beat passes through an input register and
// a result register, with the carry chain and month length lookup between
// them. Every beat gives exactly one result beat holding the time and date
// after it plus day and year rollover flags. After reset the clock reads
// 2004-12-31 23:59:56.
module calendar_clock_counter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [ccc_pkg::SetW-1:0]      set_hour_i,
  input  logic [ccc_pkg::SetW-1:0]      set_minute_i,
  input  logic [ccc_pkg::SetW-1:0]      set_second_i,
  input  logic [ccc_pkg::YearW-1:0]     set_year_i,
  input  logic [ccc_pkg::MonthW-1:0]    set_month_i,
  input  logic [ccc_pkg::DayW-1:0]      set_day_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ccc_pkg::HourW-1:0]     hour_out_o,
  output logic [ccc_pkg::MinW-1:0]      minute_out_o,
  output logic [ccc_pkg::SecW-1:0]      second_out_o,
  output logic [ccc_pkg::YearW-1:0]     year_out_o,
  output logic [ccc_pkg::MonthW-1:0]    month_out_o,
  output logic [ccc_pkg::DayW-1:0]      day_out_o,
  output logic                          day_rollover_o,
  output logic                          year_rollover_o
);

`include "calendar_clock_counter_unit_macros.svh"

  // input register
  logic                         in_vld_q;
  logic                         mode_q;
  logic [ccc_pkg::SetW-1:0]     set_hour_q, set_minute_q, set_second_q;
  logic [ccc_pkg::YearW-1:0]    set_year_q;
  logic [ccc_pkg::MonthW-1:0]   set_month_q;
  logic [ccc_pkg::DayW-1:0]     set_day_q;

  // clock and calendar state
  logic [ccc_pkg::HourW-1:0]    hour_q, hour_d;
  logic [ccc_pkg::MinW-1:0]     min_q, min_d;
  logic [ccc_pkg::SecW-1:0]     sec_q, sec_d;
  logic [ccc_pkg::YearW-1:0]    year_q, year_d;
  logic [ccc_pkg::MonthW-1:0]   month_q, month_d;
  logic [ccc_pkg::DayW-1:0]     day_q, day_d;
  logic                         day_rov_d, year_rov_d;

  // result register
  logic                         out_vld_q;
  logic                         day_rov_q, year_rov_q;
  logic [ccc_pkg::HourW-1:0]    hour_out_q;
  logic [ccc_pkg::MinW-1:0]     min_out_q;
  logic [ccc_pkg::SecW-1:0]     sec_out_q;
  logic [ccc_pkg::YearW-1:0]    year_out_q;
  logic [ccc_pkg::MonthW-1:0]   month_out_q;
  logic [ccc_pkg::DayW-1:0]     day_out_q;

  logic                         adv;
  logic [ccc_pkg::DayW-1:0]     cur_len, load_len;
  logic [ccc_pkg::MonthW-1:0]   load_month;

  // flow control
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // capture the input beat
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mode_q       <= mode_i;
      set_hour_q   <= set_hour_i;
      set_minute_q <= set_minute_i;
      set_second_q <= set_second_i;
      set_year_q   <= set_year_i;
      set_month_q  <= set_month_i;
      set_day_q    <= set_day_i;
    end
  end

  // month lengths for the tick and for the load
  assign cur_len    = ccc_pkg::month_len(year_q[1:0], month_q);
  assign load_month = (set_month_q < ccc_pkg::MonthMin) ? ccc_pkg::MonthMin :
                      (set_month_q > ccc_pkg::MonthMax) ? ccc_pkg::MonthMax :
                      set_month_q;
  assign load_len   = ccc_pkg::month_len(set_year_q[1:0], load_month);

  // next state: clamped load or carry chain
  always_comb begin
    hour_d     = hour_q;
    min_d      = min_q;
    sec_d      = sec_q;
    year_d     = year_q;
    month_d    = month_q;
    day_d      = day_q;
    day_rov_d  = 1'b0;
    year_rov_d = 1'b0;
    if (mode_q) begin
      hour_d  = (set_hour_q > ccc_pkg::SetW'(ccc_pkg::HourMax)) ? ccc_pkg::HourMax :
                set_hour_q[ccc_pkg::HourW-1:0];
      min_d   = (set_minute_q > ccc_pkg::MinMax) ? ccc_pkg::MinMax : set_minute_q;
      sec_d   = (set_second_q > ccc_pkg::SecMax) ? ccc_pkg::SecMax : set_second_q;
      year_d  = set_year_q;
      month_d = load_month;
      day_d   = (set_day_q < ccc_pkg::DayMin) ? ccc_pkg::DayMin :
                (set_day_q > load_len) ? load_len : set_day_q;
    end else if (sec_q < ccc_pkg::SecMax) begin
      sec_d = sec_q + ccc_pkg::SecW'(1);
    end else begin
      sec_d = '0;
      if (min_q < ccc_pkg::MinMax) begin
        min_d = min_q + ccc_pkg::MinW'(1);
      end else begin
        min_d = '0;
        if (hour_q < ccc_pkg::HourMax) begin
          hour_d = hour_q + ccc_pkg::HourW'(1);
        end else begin
          hour_d    = '0;
          day_rov_d = 1'b1;
          if (day_q < cur_len) begin
            day_d = day_q + ccc_pkg::DayW'(1);
          end else begin
            day_d = ccc_pkg::DayMin;
            if (month_q < ccc_pkg::MonthMax) begin
              month_d = month_q + ccc_pkg::MonthW'(1);
            end else begin
              month_d    = ccc_pkg::MonthMin;
              year_d     = year_q + ccc_pkg::YearW'(1);
              year_rov_d = 1'b1;
            end
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q  <= ccc_pkg::HourRst;
      min_q   <= ccc_pkg::MinRst;
      sec_q   <= ccc_pkg::SecRst;
      year_q  <= ccc_pkg::YearRst;
      month_q <= ccc_pkg::MonthRst;
      day_q   <= ccc_pkg::DayRst;
    end else if (adv) begin
      hour_q  <= hour_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      hour_out_q  <= hour_d;
      min_out_q   <= min_d;
      sec_out_q   <= sec_d;
      year_out_q  <= year_d;
      month_out_q <= month_d;
      day_out_q   <= day_d;
      day_rov_q   <= day_rov_d;
      year_rov_q  <= year_rov_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign hour_out_o      = hour_out_q;
  assign minute_out_o    = min_out_q;
  assign second_out_o    = sec_out_q;
  assign year_out_o      = year_out_q;
  assign month_out_o     = month_out_q;
  assign day_out_o       = day_out_q;
  assign day_rollover_o  = day_rov_q;
  assign year_rollover_o = year_rov_q;

  // checks
  `CCC_ASSERT(a_year_implies_day, clk_i, rst_ni, out_vld_q && year_rov_q |-> day_rov_q)
  `CCC_ASSERT(a_day_rov_midnight, clk_i, rst_ni,
              out_vld_q && day_rov_q |-> hour_out_q == '0 && min_out_q == '0 && sec_out_q == '0)
  `CCC_ASSERT(a_adv_gives_result, clk_i, rst_ni, adv |=> out_vld_q)
  `CCC_ASSERT(a_state_holds, clk_i, rst_ni,
              !adv |=> $stable({hour_q, min_q, sec_q, year_q, month_q, day_q}))
  `CCC_ASSERT(a_state_in_range, clk_i, rst_ni,
              hour_q <= ccc_pkg::HourMax && sec_q <= ccc_pkg::SecMax &&
              month_q >= ccc_pkg::MonthMin && month_q <= ccc_pkg::MonthMax)
  `CCC_ASSERT_ALWAYS(a_reset_clears_valid, clk_i, !rst_ni |=> !out_vld_q && !in_vld_q)

endmodule
